[rtl/sdet_pkg.sv]
// shared types and constants of the step detector
package sdet_pkg;

	// configuration register indexes
	localparam logic [1:0] CFG_WEIGHT    = 2'd0;
	localparam logic [1:0] CFG_THRESHOLD = 2'd1;
	localparam logic [1:0] CFG_GAP       = 2'd2;

	localparam int CFG_INDEX_W = 2;
	localparam int CFG_DATA_W  = 16;
	localparam int WEIGHT_W    = 9;
	localparam int LEVEL_W     = 16;
	localparam int TIME_W      = 32;
	localparam int TALLY_W     = 32;

	// register values after reset
	localparam logic [WEIGHT_W-1:0] WEIGHT_RESET    = 9'd51;
	localparam logic [LEVEL_W-1:0]  THRESHOLD_RESET = 16'd1472;
	localparam logic [LEVEL_W-1:0]  GAP_RESET       = 16'd300;

	// smoothed level: 16 integer bits, 8 fraction bits
	localparam int LEVEL_FRAC = 8;
	localparam int ACC_W      = LEVEL_W + LEVEL_FRAC;
	localparam logic [ACC_W-1:0] ACC_MAX = {ACC_W{1'b1}};
	localparam logic [LEVEL_W-1:0] LEVEL_MAX = {LEVEL_W{1'b1}};

	// commands from the controller to the datapath
	typedef struct packed {
		logic       load;
		logic       sq_prod;
		logic       sq_acc;
		logic [1:0] sq_sel;
		logic       root_init;
		logic       root_step;
		logic       ema_mul;
		logic       ema_add;
		logic       commit;
	} cmd_t;

	// status from the datapath to the controller
	typedef struct packed {
		logic out_free;
	} status_t;

endpackage

[rtl/sdet_in_if.sv]
// input channel of the step detector: one acceleration sample per item
interface sdet_in_if #(
	parameter int ACCEL_WIDTH = 16
) ();
	logic                          valid;
	logic                          ready;
	logic signed [ACCEL_WIDTH-1:0] accel_x;
	logic signed [ACCEL_WIDTH-1:0] accel_y;
	logic signed [ACCEL_WIDTH-1:0] accel_z;
	logic [31:0]                   time_ms;

	modport source(output valid, accel_x, accel_y, accel_z, time_ms, input ready);
	modport sink(input valid, accel_x, accel_y, accel_z, time_ms, output ready);
endinterface

[rtl/sdet_out_if.sv]
// output channel of the step detector: one result per item
interface sdet_out_if ();
	logic        valid;
	logic        ready;
	logic        step_seen;
	logic [31:0] step_total;
	logic [15:0] smoothed_level;

	modport source(output valid, step_seen, step_total, smoothed_level, input ready);
	modport sink(input valid, step_seen, step_total, smoothed_level, output ready);
endinterface

[rtl/sdet_ctrl.sv]
// controller state machine of the step detector
module sdet_ctrl #(
	parameter int ACCEL_WIDTH = 16
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  sdet_pkg::status_t status,
	output sdet_pkg::cmd_t    cmd
);
	localparam int CNT_W = $clog2(ACCEL_WIDTH);
	localparam logic [CNT_W-1:0] SQ_LAST   = CNT_W'(3);
	localparam logic [CNT_W-1:0] ROOT_LAST = CNT_W'(ACCEL_WIDTH - 1);

	typedef enum logic [5:0] {
		ST_IDLE    = 6'b000001,
		ST_SQUARE  = 6'b000010,
		ST_ROOT    = 6'b000100,
		ST_EMA_MUL = 6'b001000,
		ST_EMA_ADD = 6'b010000,
		ST_COMMIT  = 6'b100000
	} state_t;

	state_t           state_q, state_d;
	logic [CNT_W-1:0] cnt_q, cnt_d;

	// next state and commands
	always_comb begin
		state_d = state_q;
		cnt_d   = cnt_q;
		cmd     = '0;
		in_ready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					cnt_d    = '0;
					state_d  = ST_SQUARE;
				end
			end
			ST_SQUARE: begin
				// one square per cycle into the product register, then added to the radicand
				cmd.sq_sel  = cnt_q[1:0];
				cmd.sq_prod = (cnt_q != SQ_LAST);
				cmd.sq_acc  = (cnt_q != '0);
				if (cnt_q == SQ_LAST) begin
					cmd.root_init = 1'b1;
					cnt_d         = '0;
					state_d       = ST_ROOT;
				end else begin
					cnt_d = cnt_q + 1'b1;
				end
			end
			ST_ROOT: begin
				// one root bit per cycle
				cmd.root_step = 1'b1;
				if (cnt_q == ROOT_LAST) begin
					state_d = ST_EMA_MUL;
				end else begin
					cnt_d = cnt_q + 1'b1;
				end
			end
			ST_EMA_MUL: begin
				cmd.ema_mul = 1'b1;
				state_d     = ST_EMA_ADD;
			end
			ST_EMA_ADD: begin
				cmd.ema_add = 1'b1;
				state_d     = ST_COMMIT;
			end
			ST_COMMIT: begin
				// wait for the output register to free up
				if (status.out_free) begin
					cmd.commit = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
		end
	end

endmodule

[rtl/sdet_dp.sv]
// datapath of the step detector: squares, root, smoothing, step decision
module sdet_dp #(
	parameter int ACCEL_WIDTH      = 16,
	parameter int WEIGHT_FRAC_BITS = 8
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  cfg_we,
	input  logic [sdet_pkg::CFG_INDEX_W-1:0]      cfg_index,
	input  logic [sdet_pkg::CFG_DATA_W-1:0]       cfg_data,
	input  logic signed [ACCEL_WIDTH-1:0]         accel_x,
	input  logic signed [ACCEL_WIDTH-1:0]         accel_y,
	input  logic signed [ACCEL_WIDTH-1:0]         accel_z,
	input  logic [sdet_pkg::TIME_W-1:0]           time_ms,
	input  sdet_pkg::cmd_t                        cmd,
	output sdet_pkg::status_t                     status,
	output logic                                  out_valid,
	input  logic                                  out_ready,
	output logic                                  step_seen,
	output logic [sdet_pkg::TALLY_W-1:0]          step_total,
	output logic [sdet_pkg::LEVEL_W-1:0]          smoothed_level
);
	localparam int SQ_W   = 2 * ACCEL_WIDTH;
	localparam int REM_W  = ACCEL_WIDTH + 2;
	localparam int WC_W   = WEIGHT_FRAC_BITS + 1;
	localparam int WEXT_W = (WC_W > sdet_pkg::WEIGHT_W) ? WC_W : sdet_pkg::WEIGHT_W;
	localparam int MAC_W  = WEIGHT_FRAC_BITS + sdet_pkg::ACC_W + 2;
	localparam int SHR_W  = MAC_W - WEIGHT_FRAC_BITS;
	localparam int EXT_W  = ACCEL_WIDTH + sdet_pkg::LEVEL_W;
	localparam logic [WC_W-1:0]  W_ONE = {1'b1, {WEIGHT_FRAC_BITS{1'b0}}};
	localparam logic [MAC_W-1:0] HALF  = MAC_W'(1) << (WEIGHT_FRAC_BITS - 1);

	// magnitude of a two's complement axis value
	function automatic logic [ACCEL_WIDTH-1:0] axis_abs(input logic [ACCEL_WIDTH-1:0] v);
		logic [ACCEL_WIDTH-1:0] r;
		r = v[ACCEL_WIDTH-1] ? (~v + 1'b1) : v;
		return r;
	endfunction

	logic [sdet_pkg::WEIGHT_W-1:0] weight_q;
	logic [sdet_pkg::LEVEL_W-1:0]  thr_q;
	logic [sdet_pkg::LEVEL_W-1:0]  gap_q;

	logic [ACCEL_WIDTH-1:0]        abs_q [3];
	logic [sdet_pkg::TIME_W-1:0]   time_q;
	logic [SQ_W-1:0]               prod_q;
	logic [SQ_W-1:0]               rad_q;
	logic [REM_W-1:0]              rem_q;
	logic [ACCEL_WIDTH-1:0]        root_q;
	logic [MAC_W-1:0]              mac_q;
	logic [sdet_pkg::ACC_W-1:0]    acc_q;
	logic [sdet_pkg::TALLY_W-1:0]  tally_q;
	logic [sdet_pkg::TIME_W-1:0]   last_q;

	logic                          out_valid_q;
	logic                          out_seen_q;
	logic [sdet_pkg::TALLY_W-1:0]  out_total_q;
	logic [sdet_pkg::LEVEL_W-1:0]  out_level_q;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			weight_q <= sdet_pkg::WEIGHT_RESET;
			thr_q    <= sdet_pkg::THRESHOLD_RESET;
			gap_q    <= sdet_pkg::GAP_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				sdet_pkg::CFG_WEIGHT:    weight_q <= cfg_data[sdet_pkg::WEIGHT_W-1:0];
				sdet_pkg::CFG_THRESHOLD: thr_q    <= cfg_data[sdet_pkg::LEVEL_W-1:0];
				sdet_pkg::CFG_GAP:       gap_q    <= cfg_data[sdet_pkg::LEVEL_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// shared squarer input
	logic [ACCEL_WIDTH-1:0] sq_in;
	assign sq_in = (cmd.sq_sel == 2'd0) ? abs_q[0] :
	               (cmd.sq_sel == 2'd1) ? abs_q[1] : abs_q[2];

	// one root digit: remainder with two more radicand bits against the trial
	logic [REM_W-1:0] rem_sh;
	logic [REM_W-1:0] trial;
	logic             root_ge;
	assign rem_sh  = {rem_q[ACCEL_WIDTH-1:0], rad_q[SQ_W-1 -: 2]};
	assign trial   = {root_q, 2'b01};
	assign root_ge = (rem_sh >= trial);

	// magnitude saturated to the level range
	logic [EXT_W-1:0]             root_ext;
	logic [sdet_pkg::LEVEL_W-1:0] mag;
	assign root_ext = EXT_W'(root_q);
	assign mag = (root_ext > EXT_W'(sdet_pkg::LEVEL_MAX)) ? sdet_pkg::LEVEL_MAX
	                                                      : root_ext[sdet_pkg::LEVEL_W-1:0];

	// weight clamped to one, and its complement
	logic [WEXT_W-1:0] w_ext;
	logic [WC_W-1:0]   w_c;
	logic [WC_W-1:0]   w_rest;
	assign w_ext  = WEXT_W'(weight_q);
	assign w_c    = (w_ext > WEXT_W'(W_ONE)) ? W_ONE : w_ext[WC_W-1:0];
	assign w_rest = W_ONE - w_c;

	// smoothing: new magnitude term first, then the old level term
	logic [MAC_W-1:0]          new_term;
	logic [MAC_W-1:0]          total;
	logic [SHR_W-1:0]          total_shr;
	logic [sdet_pkg::ACC_W-1:0] acc_next;
	assign new_term  = MAC_W'(w_c) * MAC_W'({mag, {sdet_pkg::LEVEL_FRAC{1'b0}}}) + HALF;
	assign total     = mac_q + MAC_W'(w_rest) * MAC_W'(acc_q);
	assign total_shr = total[MAC_W-1:WEIGHT_FRAC_BITS];
	assign acc_next  = (total_shr > SHR_W'(sdet_pkg::ACC_MAX)) ? sdet_pkg::ACC_MAX
	                                                          : total_shr[sdet_pkg::ACC_W-1:0];

	// step decision against threshold and minimum gap
	logic [sdet_pkg::TIME_W-1:0]  since_last;
	logic                         above;
	logic                         gap_ok;
	logic                         seen;
	logic [sdet_pkg::TALLY_W-1:0] tally_next;
	assign since_last = time_q - last_q;
	assign above      = (acc_q > {thr_q, {sdet_pkg::LEVEL_FRAC{1'b0}}});
	assign gap_ok     = (since_last > sdet_pkg::TIME_W'(gap_q));
	assign seen       = above && gap_ok;
	assign tally_next = (seen && (tally_q != {sdet_pkg::TALLY_W{1'b1}})) ? tally_q + 1'b1
	                                                                     : tally_q;

	// sample capture, squares and root iteration
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			abs_q[0] <= axis_abs(accel_x);
			abs_q[1] <= axis_abs(accel_y);
			abs_q[2] <= axis_abs(accel_z);
			time_q   <= time_ms;
			rad_q    <= '0;
		end
		if (cmd.sq_prod) begin
			prod_q <= SQ_W'(sq_in) * SQ_W'(sq_in);
		end
		if (cmd.sq_acc) begin
			rad_q <= rad_q + prod_q;
		end
		if (cmd.root_init) begin
			rem_q  <= '0;
			root_q <= '0;
		end
		if (cmd.root_step) begin
			rad_q  <= {rad_q[SQ_W-3:0], 2'b00};
			rem_q  <= root_ge ? (rem_sh - trial) : rem_sh;
			root_q <= {root_q[ACCEL_WIDTH-2:0], root_ge};
		end
		if (cmd.ema_mul) begin
			mac_q <= new_term;
		end
	end

	// detector state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q   <= '0;
			tally_q <= '0;
			last_q  <= '0;
		end else begin
			if (cmd.ema_add) begin
				acc_q <= acc_next;
			end
			if (cmd.commit) begin
				tally_q <= tally_next;
				if (seen) begin
					last_q <= time_q;
				end
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.commit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			out_seen_q  <= seen;
			out_total_q <= tally_next;
			out_level_q <= acc_q[sdet_pkg::ACC_W-1:sdet_pkg::LEVEL_FRAC];
		end
	end

	assign status.out_free = !out_valid_q || out_ready;
	assign out_valid       = out_valid_q;
	assign step_seen       = out_seen_q;
	assign step_total      = out_total_q;
	assign smoothed_level  = out_level_q;

endmodule

[rtl/step_detector_ema_threshold.sv]
// top level of the step detector: magnitude, smoothing and step count
//
// in_ch takes one item per sample: three signed acceleration axes and a
// millisecond timestamp. out_ch gives one item per sample: whether a step
// was counted, the saturating step total and the integer smoothed level.
// The cfg port writes smoothing weight (0), threshold (1) and minimum gap (2)
// at any clock edge with cfg_we high; write only while no sample is in work.
// An item is accepted only while the controller is idle. The squares are
// formed on one shared multiplier, the square root is worked out at one bit
// per cycle, then smoothing multiplies and adds, and the decision follows.
// A new sample is taken only after the current one has been committed; the
// bit-serial root takes the largest share of the work on each sample.
// A finished result sits in the output register while the next sample is
// accepted and worked; if the receiver still stalls when that sample is
// done, the controller holds it until the register frees.
// Reset clears the level, the step total and the last step time, and loads
// the reset values of the three registers.
module step_detector_ema_threshold #(
	parameter int ACCEL_WIDTH      = 16,
	parameter int WEIGHT_FRAC_BITS = 8
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [sdet_pkg::CFG_INDEX_W-1:0]  cfg_index,
	input  logic [sdet_pkg::CFG_DATA_W-1:0]   cfg_data,
	sdet_in_if.sink                           in_ch,
	sdet_out_if.source                        out_ch
);
	sdet_pkg::cmd_t    cmd;
	sdet_pkg::status_t status;
	logic              in_ready;

	// controller
	sdet_ctrl #(
		.ACCEL_WIDTH(ACCEL_WIDTH)
	) u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(in_ch.valid),
		.in_ready(in_ready),
		.status  (status),
		.cmd     (cmd)
	);

	assign in_ch.ready = in_ready;

	// datapath
	sdet_dp #(
		.ACCEL_WIDTH     (ACCEL_WIDTH),
		.WEIGHT_FRAC_BITS(WEIGHT_FRAC_BITS)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.accel_x       (in_ch.accel_x),
		.accel_y       (in_ch.accel_y),
		.accel_z       (in_ch.accel_z),
		.time_ms       (in_ch.time_ms),
		.cmd           (cmd),
		.status        (status),
		.out_valid     (out_ch.valid),
		.out_ready     (out_ch.ready),
		.step_seen     (out_ch.step_seen),
		.step_total    (out_ch.step_total),
		.smoothed_level(out_ch.smoothed_level)
	);

`ifndef SYNTHESIS
	// no second item is taken while one is in work
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_ch.valid && in_ch.ready |=> !in_ch.ready)
		else $error("item accepted while the previous one was in work");

	// a result is never written over one still waiting
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |-> (!out_ch.valid || out_ch.ready))
		else $error("result overwritten before it was taken");

	// a committed result shows up on the output
	a_commit_visible: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |=> out_ch.valid)
		else $error("committed result not presented");
`endif

endmodule
